// ===== src/gmnc_pkg.sv =====
// shared types, constants and helper functions for the grid mesh neighbor code block
package gmnc_pkg;

  localparam int CODE_W  = 27;  // decimal mesh code
  localparam int OFF_W   = 8;   // signed cell offset
  localparam int SUM_W   = 10;  // signed working width for field arithmetic
  localparam int PAIR_W  = 7;   // two-digit decimal field, 0..99
  localparam int DIGIT_W = 4;   // one decimal digit
  localparam int OCT_W   = 3;   // one octal digit
  localparam int QUAD_W  = 14;  // four-digit decimal field, 0..9999
  localparam int PIPE_DEPTH = 9;

  localparam logic [CODE_W-1:0] CODE_MOD = 27'd100000000;
  localparam logic [CODE_W-1:0] CODE_MAX = 27'd99999999;
  localparam logic [CODE_W-1:0] QUAD_BASE = 27'd10000;

  // reciprocal constants: floor(2^s / d) for 10000, ceil(2^s / d) for 100 and 10
  localparam logic [QUAD_W-1:0] DIV_10K_MUL   = 14'd13421;
  localparam int                DIV_10K_SHIFT = 27;
  localparam logic [12:0]       DIV_100_MUL   = 13'd5243;
  localparam int                DIV_100_SHIFT = 19;
  localparam logic [7:0]        DIV_10_MUL    = 8'd205;
  localparam int                DIV_10_SHIFT  = 11;

  localparam logic signed [SUM_W-1:0] TOP_MAX = 10'sd99;

  typedef enum logic [1:0] {
    LVL_FIRST  = 2'd0,
    LVL_SECOND = 2'd1,
    LVL_EIGHT  = 2'd2,
    LVL_UNUSED = 2'd3
  } mesh_level_t;

  typedef struct packed {
    logic signed [OFF_W-1:0] dx;
    logic signed [OFF_W-1:0] dy;
  } offs_t;

  // two-digit pairs of the 8-digit code, most significant first
  typedef struct packed {
    logic [PAIR_W-1:0] hh;
    logic [PAIR_W-1:0] hl;
    logic [PAIR_W-1:0] lh;
    logic [PAIR_W-1:0] ll;
  } dec_pairs_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] tens;
    logic [DIGIT_W-1:0] ones;
  } digit_pair_t;

  // fields picked out by level, before offsets
  typedef struct packed {
    logic [PAIR_W-1:0]  yt;
    logic [PAIR_W-1:0]  xt;
    logic [DIGIT_W-1:0] y1;
    logic [DIGIT_W-1:0] x1;
    logic [DIGIT_W-1:0] y2;
    logic [DIGIT_W-1:0] x2;
  } mesh_fields_t;

  // fields after offsets and range check
  typedef struct packed {
    logic               bad;
    logic [PAIR_W-1:0]  yt;
    logic [PAIR_W-1:0]  xt;
    logic [OCT_W-1:0]   y1;
    logic [OCT_W-1:0]   x1;
    logic [OCT_W-1:0]   y2;
    logic [OCT_W-1:0]   x2;
  } step_fields_t;

  // split 0..99 into tens and ones
  function automatic digit_pair_t dec_digits(input logic [PAIR_W-1:0] n);
    logic [14:0]       prod;
    logic [PAIR_W-1:0] rest;
    digit_pair_t       d;
    prod   = {8'd0, n} * {7'd0, DIV_10_MUL};
    d.tens = prod[DIV_10_SHIFT +: DIGIT_W];
    rest   = n - ({3'd0, d.tens} * 7'd10);
    d.ones = rest[DIGIT_W-1:0];
    return d;
  endfunction

endpackage

// ===== src/gmnc_split.sv =====
// decimal split of the mesh code into four two-digit pairs, five register stages
module gmnc_split (
  input  logic                             clk,
  input  logic                             adv,
  input  logic [gmnc_pkg::CODE_W-1:0]      code_in,
  input  gmnc_pkg::offs_t                  offs_in,
  output gmnc_pkg::dec_pairs_t             pairs,
  output gmnc_pkg::offs_t                  offs_out
);

  // offsets ride along with the code
  gmnc_pkg::offs_t offs_r [0:4];

  logic [gmnc_pkg::CODE_W-1:0] c8_nxt, c8_r, c8_dly_r;
  logic [40:0]                 prod10k;
  logic [gmnc_pkg::QUAD_W-1:0] qest_nxt, qest_r;
  logic [gmnc_pkg::CODE_W-1:0] rem_full;
  logic [14:0]                 rem;
  logic [gmnc_pkg::QUAD_W-1:0] hi4_nxt, lo4_nxt, hi4_r, lo4_r, hi4_dly_r, lo4_dly_r;
  logic [26:0]                 prod_hi, prod_lo;
  logic [gmnc_pkg::PAIR_W-1:0] qh_nxt, ql_nxt, qh_r, ql_r;
  logic [gmnc_pkg::QUAD_W-1:0] rh_full, rl_full;
  gmnc_pkg::dec_pairs_t        pairs_nxt, pairs_r;

  // stage 1: fold to 8 digits, the code is below twice the modulus
  assign c8_nxt = (code_in >= gmnc_pkg::CODE_MOD) ? code_in - gmnc_pkg::CODE_MOD : code_in;

  // stage 2: quotient estimate by 10000, may be one low
  assign prod10k  = {14'd0, c8_r} * {27'd0, gmnc_pkg::DIV_10K_MUL};
  assign qest_nxt = prod10k[gmnc_pkg::DIV_10K_SHIFT +: gmnc_pkg::QUAD_W];

  // stage 3: remainder and one correction step
  assign rem_full = c8_dly_r - ({13'd0, qest_r} * gmnc_pkg::QUAD_BASE);
  assign rem      = rem_full[14:0];

  always_comb begin
    if (rem >= 15'd10000) begin
      hi4_nxt = qest_r + 14'd1;
      lo4_nxt = 14'(rem - 15'd10000);
    end else begin
      hi4_nxt = qest_r;
      lo4_nxt = rem[gmnc_pkg::QUAD_W-1:0];
    end
  end

  // stage 4: divide both halves by 100, exact below 10000
  assign prod_hi = {13'd0, hi4_r} * {14'd0, gmnc_pkg::DIV_100_MUL};
  assign prod_lo = {13'd0, lo4_r} * {14'd0, gmnc_pkg::DIV_100_MUL};
  assign qh_nxt  = prod_hi[gmnc_pkg::DIV_100_SHIFT +: gmnc_pkg::PAIR_W];
  assign ql_nxt  = prod_lo[gmnc_pkg::DIV_100_SHIFT +: gmnc_pkg::PAIR_W];

  // stage 5: remainders by 100
  assign rh_full = hi4_dly_r - ({7'd0, qh_r} * 14'd100);
  assign rl_full = lo4_dly_r - ({7'd0, ql_r} * 14'd100);

  always_comb begin
    pairs_nxt.hh = qh_r;
    pairs_nxt.hl = rh_full[gmnc_pkg::PAIR_W-1:0];
    pairs_nxt.lh = ql_r;
    pairs_nxt.ll = rl_full[gmnc_pkg::PAIR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c8_r      <= c8_nxt;
      c8_dly_r  <= c8_r;
      qest_r    <= qest_nxt;
      hi4_r     <= hi4_nxt;
      lo4_r     <= lo4_nxt;
      hi4_dly_r <= hi4_r;
      lo4_dly_r <= lo4_r;
      qh_r      <= qh_nxt;
      ql_r      <= ql_nxt;
      pairs_r   <= pairs_nxt;
      offs_r[0] <= offs_in;
      offs_r[1] <= offs_r[0];
      offs_r[2] <= offs_r[1];
      offs_r[3] <= offs_r[2];
      offs_r[4] <= offs_r[3];
    end
  end

  assign pairs    = pairs_r;
  assign offs_out = offs_r[4];

endmodule

// ===== src/gmnc_offset.sv =====
// field selection by level, octal offset add with carry, range check
module gmnc_offset (
  input  logic                   clk,
  input  logic                   adv,
  input  gmnc_pkg::mesh_level_t  level,
  input  gmnc_pkg::dec_pairs_t   pairs,
  input  gmnc_pkg::offs_t        offs_in,
  output gmnc_pkg::step_fields_t fields
);

  typedef struct packed {
    logic signed [gmnc_pkg::SUM_W-1:0] top;
    logic [gmnc_pkg::OCT_W-1:0]        d1;
    logic [gmnc_pkg::OCT_W-1:0]        d2;
  } axis_t;

  gmnc_pkg::digit_pair_t  lh_dig, ll_dig;
  gmnc_pkg::mesh_fields_t sel_nxt, sel_r;
  gmnc_pkg::offs_t        offs_r;
  axis_t                  x_ax, y_ax;
  gmnc_pkg::step_fields_t step_nxt, step_r;

  // one axis: offset enters the lowest octal digit (the top field at first level), floor carry upward
  function automatic axis_t axis_step(
    input gmnc_pkg::mesh_level_t        lvl,
    input logic [gmnc_pkg::PAIR_W-1:0]  top,
    input logic [gmnc_pkg::DIGIT_W-1:0] d1,
    input logic [gmnc_pkg::DIGIT_W-1:0] d2,
    input logic signed [gmnc_pkg::OFF_W-1:0] off
  );
    logic signed [gmnc_pkg::SUM_W-1:0] top_e, d1_e, d2_e, off_e, sa, ca, t, cb;
    axis_t a;
    top_e = $signed({3'd0, top});
    d1_e  = $signed({6'd0, d1});
    d2_e  = $signed({6'd0, d2});
    off_e = $signed({{2{off[gmnc_pkg::OFF_W-1]}}, off});
    a.top = top_e + off_e;
    a.d1  = '0;
    a.d2  = '0;
    case (lvl)
      gmnc_pkg::LVL_SECOND: begin
        sa    = d1_e + off_e;
        ca    = sa >>> 3;
        a.top = top_e + ca;
        a.d1  = sa[gmnc_pkg::OCT_W-1:0];
      end
      gmnc_pkg::LVL_EIGHT: begin
        sa    = d2_e + off_e;
        ca    = sa >>> 3;
        t     = d1_e + ca;
        cb    = t >>> 3;
        a.top = top_e + cb;
        a.d1  = t[gmnc_pkg::OCT_W-1:0];
        a.d2  = sa[gmnc_pkg::OCT_W-1:0];
      end
      default: begin
        a.top = top_e + off_e;
      end
    endcase
    return a;
  endfunction

  // stage 6: pick fields for the level
  assign lh_dig = gmnc_pkg::dec_digits(pairs.lh);
  assign ll_dig = gmnc_pkg::dec_digits(pairs.ll);

  always_comb begin
    sel_nxt = '0;
    case (level)
      gmnc_pkg::LVL_FIRST: begin
        sel_nxt.yt = pairs.lh;
        sel_nxt.xt = pairs.ll;
      end
      gmnc_pkg::LVL_SECOND: begin
        sel_nxt.yt = pairs.hl;
        sel_nxt.xt = pairs.lh;
        sel_nxt.y1 = ll_dig.tens;
        sel_nxt.x1 = ll_dig.ones;
      end
      gmnc_pkg::LVL_EIGHT: begin
        sel_nxt.yt = pairs.hh;
        sel_nxt.xt = pairs.hl;
        sel_nxt.y1 = lh_dig.tens;
        sel_nxt.x1 = lh_dig.ones;
        sel_nxt.y2 = ll_dig.tens;
        sel_nxt.x2 = ll_dig.ones;
      end
      default: begin
        sel_nxt = '0;
      end
    endcase
  end

  // stage 7: offsets and range check
  assign x_ax = axis_step(level, sel_r.xt, sel_r.x1, sel_r.x2, offs_r.dx);
  assign y_ax = axis_step(level, sel_r.yt, sel_r.y1, sel_r.y2, offs_r.dy);

  always_comb begin
    step_nxt.bad = (level == gmnc_pkg::LVL_UNUSED) ||
                   (x_ax.top < 0) || (x_ax.top > gmnc_pkg::TOP_MAX) ||
                   (y_ax.top < 0) || (y_ax.top > gmnc_pkg::TOP_MAX);
    step_nxt.xt  = x_ax.top[gmnc_pkg::PAIR_W-1:0];
    step_nxt.yt  = y_ax.top[gmnc_pkg::PAIR_W-1:0];
    step_nxt.x1  = x_ax.d1;
    step_nxt.y1  = y_ax.d1;
    step_nxt.x2  = x_ax.d2;
    step_nxt.y2  = y_ax.d2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sel_r  <= sel_nxt;
      offs_r <= offs_in;
      step_r <= step_nxt;
    end
  end

  assign fields = step_r;

endmodule

// ===== src/gmnc_join.sv =====
// rebuild the decimal code from the shifted fields, two register stages
module gmnc_join (
  input  logic                         clk,
  input  logic                         adv,
  input  gmnc_pkg::mesh_level_t        level,
  input  gmnc_pkg::step_fields_t       fields,
  output logic [gmnc_pkg::CODE_W-1:0]  code_out,
  output logic                         bad_out
);

  logic [gmnc_pkg::QUAD_W-1:0] p_nxt, q_nxt, p_r, q_r;
  logic                        bad_r, bad_dly_r;
  logic [gmnc_pkg::CODE_W-1:0] code_nxt, code_r;

  // stage 8: upper and lower four-digit halves
  always_comb begin
    p_nxt = '0;
    q_nxt = '0;
    case (level)
      gmnc_pkg::LVL_FIRST: begin
        q_nxt = ({7'd0, fields.yt} * 14'd100) + {7'd0, fields.xt};
      end
      gmnc_pkg::LVL_SECOND: begin
        p_nxt = {7'd0, fields.yt};
        q_nxt = ({7'd0, fields.xt} * 14'd100) + ({11'd0, fields.y1} * 14'd10) +
                {11'd0, fields.x1};
      end
      gmnc_pkg::LVL_EIGHT: begin
        p_nxt = ({7'd0, fields.yt} * 14'd100) + {7'd0, fields.xt};
        q_nxt = ({11'd0, fields.y1} * 14'd1000) + ({11'd0, fields.x1} * 14'd100) +
                ({11'd0, fields.y2} * 14'd10) + {11'd0, fields.x2};
      end
      default: begin
        p_nxt = '0;
        q_nxt = '0;
      end
    endcase
    if (fields.bad) begin
      p_nxt = '0;
      q_nxt = '0;
    end
  end

  // stage 9: join halves
  assign code_nxt = ({13'd0, p_r} * gmnc_pkg::QUAD_BASE) + {13'd0, q_r};

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r       <= p_nxt;
      q_r       <= q_nxt;
      bad_r     <= fields.bad;
      code_r    <= code_nxt;
      bad_dly_r <= bad_r;
    end
  end

  assign code_out = code_r;
  assign bad_out  = bad_dly_r;

endmodule

// ===== src/grid_mesh_neighbor_code_core.sv =====
// top level of the grid mesh neighbor code block: pipeline control and config register
//
// channel   | handshake             | payload
// ----------+-----------------------+--------------------------------------------
// input     | in_valid / in_stall   | in_mesh_code, in_x_offset, in_y_offset
// result    | out_valid / out_stall | out_neighbor_code, out_out_of_range
// config    | cfg_wr_en             | cfg_wr_data (mesh level)
//
// one item per cycle while the result is not stalled
// the split stages form the reciprocal divide chain: fold, estimate, correct, /100, rem
// reset clears the valid line and sets the level to second level (6 digits)
// a stalled result freezes every stage; in_stall follows out_stall while out_valid
module grid_mesh_neighbor_code_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [gmnc_pkg::CODE_W-1:0]       in_mesh_code,
  input  logic signed [gmnc_pkg::OFF_W-1:0] in_x_offset,
  input  logic signed [gmnc_pkg::OFF_W-1:0] in_y_offset,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [gmnc_pkg::CODE_W-1:0]       out_neighbor_code,
  output logic                              out_out_of_range,
  input  logic                              cfg_wr_en,
  input  logic [1:0]                        cfg_wr_data
);

  // mesh level register
  gmnc_pkg::mesh_level_t level_r;

  // one valid bit per pipeline stage
  logic [gmnc_pkg::PIPE_DEPTH-1:0] vld_r, vld_nxt;

  // whole pipe moves unless a finished item is held at the output
  logic adv;

  gmnc_pkg::offs_t        offs_in, offs_split;
  gmnc_pkg::dec_pairs_t   pairs;
  gmnc_pkg::step_fields_t fields;

  assign adv      = !(vld_r[gmnc_pkg::PIPE_DEPTH-1] && out_stall);
  assign in_stall = !adv;

  assign vld_nxt = {vld_r[gmnc_pkg::PIPE_DEPTH-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      level_r <= gmnc_pkg::LVL_SECOND;
    end else begin
      if (adv) begin
        vld_r <= vld_nxt;
      end
      if (cfg_wr_en) begin
        level_r <= gmnc_pkg::mesh_level_t'(cfg_wr_data);
      end
    end
  end

  assign offs_in.dx = in_x_offset;
  assign offs_in.dy = in_y_offset;

  // stages 1-5: decimal split
  gmnc_split u_split (
    .clk      (clk),
    .adv      (adv),
    .code_in  (in_mesh_code),
    .offs_in  (offs_in),
    .pairs    (pairs),
    .offs_out (offs_split)
  );

  // stages 6-7: field select, octal carry, range check
  gmnc_offset u_offset (
    .clk     (clk),
    .adv     (adv),
    .level   (level_r),
    .pairs   (pairs),
    .offs_in (offs_split),
    .fields  (fields)
  );

  // stages 8-9: rebuild code, output register
  gmnc_join u_join (
    .clk      (clk),
    .adv      (adv),
    .level    (level_r),
    .fields   (fields),
    .code_out (out_neighbor_code),
    .bad_out  (out_out_of_range)
  );

  assign out_valid = vld_r[gmnc_pkg::PIPE_DEPTH-1];

  // flagged result carries a zero code
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_range) |-> (out_neighbor_code == '0))
    else $error("flagged item with nonzero code");

  // good result stays within eight decimal digits
  a_code_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_out_of_range) |-> (out_neighbor_code <= gmnc_pkg::CODE_MAX))
    else $error("neighbor code beyond eight digits");

  // input back-pressure only comes from a held result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // an accepted item enters the first stage
  a_accept_vld: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("accepted item lost at pipe entry");

endmodule
